/* sv/wmmio_pkg.sv */
// ---------------------------------------------------------------------------
// wmmio_pkg
// shared types and address constants for the word memory with mapped io
// ---------------------------------------------------------------------------
package wmmio_pkg;

    // access kind carried in the input tuser
    typedef enum logic [1:0] {
        MODE_DATA_READ  = 2'd0,
        MODE_DATA_WRITE = 2'd1,
        MODE_FETCH      = 2'd2
    } mode_t;

    // data access width
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_WRITE_RX    = 3'd1,
        ERR_READ_TX     = 3'd2,
        ERR_READ_LED    = 3'd3,
        ERR_DATA_RANGE  = 3'd4,
        ERR_FETCH_RANGE = 3'd5
    } err_t;

    // byte addresses of the mapped ports and the data region
    localparam logic [31:0] UART_RX_BYTE_ADDR = 32'h0002_0000;
    localparam logic [31:0] UART_TX_BYTE_ADDR = 32'h0002_0004;
    localparam logic [31:0] LED_BYTE_ADDR     = 32'h0002_0008;
    localparam logic [31:0] DATA_BYTE_SPACE   = 32'h000f_4240;
    localparam logic [31:0] WORD_BYTES        = 32'd4;

    localparam logic [29:0] UART_RX_WORD = UART_RX_BYTE_ADDR[31:2];
    localparam logic [29:0] UART_TX_WORD = UART_TX_BYTE_ADDR[31:2];
    localparam logic [29:0] LED_WORD     = LED_BYTE_ADDR[31:2];

    // a data word is in range while 4 * addr + 4 <= DATA_BYTE_SPACE
    localparam logic [31:0] DATA_LIMIT_WORDS =
        (DATA_BYTE_SPACE - WORD_BYTES) / WORD_BYTES + 32'd1;

    // one result, read data aside when it comes from the ram
    typedef struct packed {
        logic        from_mem;
        logic [3:0]  lanes;
        logic [31:0] read_data;
        logic        uart_rx_pop;
        logic        uart_tx_valid;
        logic [7:0]  uart_tx_byte;
        logic        led_valid;
        logic [7:0]  led_value;
        err_t        error_code;
    } result_t;

endpackage

/* sv/wmmio_ram.sv */
// ---------------------------------------------------------------------------
// wmmio_ram
// single-port synchronous ram with byte lane writes and registered read
// ---------------------------------------------------------------------------
module wmmio_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     re,
    input  logic [WIDTH/8-1:0]       we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIDTH / 8; i++)
        begin
            if (we[i])
            begin
                mem[addr][i*8 +: 8] <= wdata[i*8 +: 8];
            end
        end
        // read data holds while no read is issued
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/word_memory_with_mapped_io.sv */
// ---------------------------------------------------------------------------
// word_memory_with_mapped_io
// word-addressed data and instruction memory with uart and led ports
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one access per beat: tuser holds the mode (data read,
//   data write, instruction fetch), tdata the word address, access size,
//   write data and the byte currently offered by the uart receiver.
//   m_axis returns exactly one result beat per access: read data, uart
//   receive pop, uart transmit byte, led byte and an error code.
//   three word addresses are ports: uart receive (read only), uart
//   transmit and led (write only); wrong direction gives an error code.
//   out-of-range data accesses and fetches give an error and read as 0.
//   the result appears in the cycle after the access beat.
//   throughput: one access per cycle, set by the single ram port; a write
//   lands at the accept edge so the next beat already reads it.
//   the read data register of the ram doubles as the output register.
//   when the receiver stalls, the result holds and s_axis_tready drops
//   until the result beat is taken, so no ram read is lost.
//   reset clears only the handshake state; the ram has no clearing pass,
//   its contents are undefined until written.
// ---------------------------------------------------------------------------
module word_memory_with_mapped_io #(
    parameter int MEM_WORDS         = 262144,
    parameter int FETCH_LIMIT_WORDS = 32767
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // word_address[29:0], access_size[31:30], write_data[63:32],
    // uart_rx_byte[71:64]
    input  logic [71:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[31:0], uart_rx_pop[32], uart_tx_valid[33],
    // uart_tx_byte[41:34], led_valid[42], led_value[50:43],
    // error_code[53:51], zero pad[55:54]
    output logic [55:0] m_axis_tdata
);

    import wmmio_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    // input fields
    logic [29:0] word_address;
    logic [1:0]  access_size;
    logic [31:0] write_data;
    logic [7:0]  uart_rx_byte;
    logic [31:0] wa_ext;

    assign word_address = s_axis_tdata[29:0];
    assign access_size  = s_axis_tdata[31:30];
    assign write_data   = s_axis_tdata[63:32];
    assign uart_rx_byte = s_axis_tdata[71:64];
    assign wa_ext       = {2'b00, word_address};

    logic        accept;
    logic        data_ok;
    logic        fetch_ok;
    logic [3:0]  size_lanes;
    logic        ram_re;
    logic [3:0]  ram_we;
    logic [31:0] ram_rdata;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;
    result_t res_next;

    // a result slot frees up as the pending beat leaves
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign data_ok  = (wa_ext < DATA_LIMIT_WORDS) && (wa_ext < 32'(MEM_WORDS));
    assign fetch_ok = (wa_ext < 32'(FETCH_LIMIT_WORDS)) && (wa_ext < 32'(MEM_WORDS));

    // little-endian low lanes; size three acts as a word
    always_comb
    begin
        case (access_size)
            SIZE_BYTE: size_lanes = 4'b0001;
            SIZE_HALF: size_lanes = 4'b0011;
            default:   size_lanes = 4'b1111;
        endcase
    end

    // decode one access; ports win over the range check
    always_comb
    begin
        res_next            = '0;
        res_next.error_code = ERR_NONE;
        ram_re              = 1'b0;
        ram_we              = 4'b0000;
        unique case (s_axis_tuser)
            MODE_DATA_READ:
            begin
                if (word_address == UART_RX_WORD)
                begin
                    res_next.read_data   = {24'd0, uart_rx_byte};
                    res_next.uart_rx_pop = 1'b1;
                end
                else if (word_address == UART_TX_WORD)
                begin
                    res_next.error_code = ERR_READ_TX;
                end
                else if (word_address == LED_WORD)
                begin
                    res_next.error_code = ERR_READ_LED;
                end
                else if (!data_ok)
                begin
                    res_next.error_code = ERR_DATA_RANGE;
                end
                else
                begin
                    res_next.from_mem = 1'b1;
                    res_next.lanes    = size_lanes;
                    ram_re            = 1'b1;
                end
            end
            MODE_DATA_WRITE:
            begin
                if (word_address == UART_RX_WORD)
                begin
                    res_next.error_code = ERR_WRITE_RX;
                end
                else if (word_address == UART_TX_WORD)
                begin
                    res_next.uart_tx_valid = 1'b1;
                    res_next.uart_tx_byte  = write_data[7:0];
                end
                else if (word_address == LED_WORD)
                begin
                    res_next.led_valid = 1'b1;
                    res_next.led_value = write_data[7:0];
                end
                else if (!data_ok)
                begin
                    res_next.error_code = ERR_DATA_RANGE;
                end
                else
                begin
                    ram_we = size_lanes;
                end
            end
            MODE_FETCH:
            begin
                if (fetch_ok)
                begin
                    res_next.from_mem = 1'b1;
                    res_next.lanes    = 4'b1111;
                    ram_re            = 1'b1;
                end
                else
                begin
                    res_next.error_code = ERR_FETCH_RANGE;
                end
            end
            default:
            begin
                // mode three: no access, all-zero result
            end
        endcase
    end

    wmmio_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .re    (ram_re && accept),
        .we    (ram_we & {4{accept}}),
        .addr  (word_address[AW-1:0]),
        .wdata (write_data),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // mask the ram word down to the accessed lanes
    logic [31:0] lane_mask;
    logic [31:0] read_data;

    assign lane_mask = {{8{res_reg.lanes[3]}}, {8{res_reg.lanes[2]}},
                        {8{res_reg.lanes[1]}}, {8{res_reg.lanes[0]}}};
    assign read_data = res_reg.from_mem ? (ram_rdata & lane_mask) : res_reg.read_data;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            res_reg.error_code,
                            res_reg.led_value,
                            res_reg.led_valid,
                            res_reg.uart_tx_byte,
                            res_reg.uart_tx_valid,
                            res_reg.uart_rx_pop,
                            read_data};

`ifndef NO_ASSERTIONS
    // every accepted access yields a result beat next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted access produced no result");

    // errors always come with zero read data
    a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[53:51] != ERR_NONE) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("error result with nonzero read data");

    // at most one port side effect per result: rx pop, tx valid, led valid
    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $countones({m_axis_tdata[42], m_axis_tdata[33:32]}) <= 1)
        else $error("more than one port action in one result");

    // the ram is never touched by a decode that produced an error
    a_no_ram_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_next.error_code != ERR_NONE) |-> (ram_we == 4'b0000 && !ram_re))
        else $error("ram access issued on an error");
`endif

endmodule

/* sim/tb_word_memory_with_mapped_io.sv */
// ---------------------------------------------------------------------------
// tb_word_memory_with_mapped_io
// self-checking bench for the word memory with uart and led ports: a
// scoreboard keeps its own image of the ram and predicts every result beat,
// while random idling on both stream sides moves gaps across the pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_word_memory_with_mapped_io;

    import wmmio_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_WIDE = 2'd3;   // behaves as a word access
    localparam logic [1:0] MODE_NONE = 2'd3;   // no access at all

    localparam int MEM_SLOTS       = 262144;
    localparam int FETCH_LIMIT     = 32767;
    localparam int RANDOM_ACCESSES = 1200;
    localparam int QUIET_TAIL      = 200;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 400000;

    // one access as it enters the block
    typedef struct {
        logic [1:0]  mode;
        logic [29:0] word_address;
        logic [1:0]  access_size;
        logic [31:0] write_data;
        logic [7:0]  uart_rx_byte;
    } access_t;

    // one result beat as the block should return it
    typedef struct {
        logic [31:0] read_data;
        logic        rx_pop;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        led_valid;
        logic [7:0]  led_value;
        err_t        error_code;
    } response_t;

    // -----------------------------------------------------------------------
    // scoreboard: ram image, per-slot written lanes and the responses due
    // -----------------------------------------------------------------------
    class mmio_scoreboard;
        logic [31:0] word_image [int];
        logic [3:0]  lanes_written [int];
        int          written_slots [$];
        response_t   responses_due [$];
        int          mismatches = 0;
        int          strays     = 0;
        int          reports    = 0;
        int          checked    = 0;
        int          mem_reads  = 0;
        int          mem_writes = 0;
        int          fetches    = 0;
        int          port_hits  = 0;
        int          faults     = 0;
        int          idle_ops   = 0;

        // byte lanes touched by a data access; size three counts as a word
        function logic [3:0] size_lanes(logic [1:0] size);
            if (size == SIZE_BYTE)
                return 4'b0001;
            if (size == SIZE_HALF)
                return 4'b0011;
            return 4'b1111;
        endfunction

        // work out the result of one access and update the ram image
        function response_t apply_access(access_t a);
            response_t   r;
            logic [3:0]  lanes;
            logic [31:0] mask;
            logic [31:0] held;
            int          slot;
            lanes = size_lanes(a.access_size);
            mask  = {{8{lanes[3]}}, {8{lanes[2]}}, {8{lanes[1]}}, {8{lanes[0]}}};
            slot  = int'(a.word_address);
            held  = word_image.exists(slot) ? word_image[slot] : 32'h0;
            r.read_data  = '0;
            r.rx_pop     = 1'b0;
            r.tx_valid   = 1'b0;
            r.tx_byte    = '0;
            r.led_valid  = 1'b0;
            r.led_value  = '0;
            r.error_code = ERR_NONE;
            case (a.mode)
                MODE_DATA_READ: begin
                    // ports are decoded ahead of the range check
                    if (a.word_address == UART_RX_WORD) begin
                        r.read_data = {24'h0, a.uart_rx_byte};
                        r.rx_pop    = 1'b1;
                        port_hits++;
                    end else if (a.word_address == UART_TX_WORD) begin
                        r.error_code = ERR_READ_TX;
                    end else if (a.word_address == LED_WORD) begin
                        r.error_code = ERR_READ_LED;
                    end else if (a.word_address >= DATA_LIMIT_WORDS ||
                                 a.word_address >= MEM_SLOTS) begin
                        r.error_code = ERR_DATA_RANGE;
                    end else begin
                        r.read_data = held & mask;
                        mem_reads++;
                    end
                end
                MODE_DATA_WRITE: begin
                    if (a.word_address == UART_RX_WORD) begin
                        r.error_code = ERR_WRITE_RX;
                    end else if (a.word_address == UART_TX_WORD) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = a.write_data[7:0];
                        port_hits++;
                    end else if (a.word_address == LED_WORD) begin
                        r.led_valid = 1'b1;
                        r.led_value = a.write_data[7:0];
                        port_hits++;
                    end else if (a.word_address >= DATA_LIMIT_WORDS ||
                                 a.word_address >= MEM_SLOTS) begin
                        r.error_code = ERR_DATA_RANGE;
                    end else begin
                        if (!lanes_written.exists(slot)) begin
                            lanes_written[slot] = 4'b0000;
                            written_slots.push_back(slot);
                        end
                        word_image[slot]    = (held & ~mask) | (a.write_data & mask);
                        lanes_written[slot] = lanes_written[slot] | lanes;
                        mem_writes++;
                    end
                end
                MODE_FETCH: begin
                    if (a.word_address < FETCH_LIMIT && a.word_address < MEM_SLOTS) begin
                        r.read_data = held;
                        fetches++;
                    end else begin
                        r.error_code = ERR_FETCH_RANGE;
                    end
                end
                default: idle_ops++;
            endcase
            if (r.error_code != ERR_NONE)
                faults++;
            return r;
        endfunction

        // an input beat was taken: queue what it must produce
        function void note_access(access_t a);
            responses_due.push_back(apply_access(a));
        endfunction

        // a result beat was taken: compare it with the oldest response due
        function void check_result(logic [55:0] d);
            response_t e;
            if (responses_due.size() == 0) begin
                strays++;
                reports++;
                if (reports <= 10)
                    $display("result beat with nothing due: tdata=%h", d);
                return;
            end
            e = responses_due.pop_front();
            checked++;
            if (d[31:0] !== e.read_data || d[32] !== e.rx_pop || d[33] !== e.tx_valid ||
                d[41:34] !== e.tx_byte || d[42] !== e.led_valid ||
                d[50:43] !== e.led_value || d[53:51] !== e.error_code) begin
                mismatches++;
                reports++;
                if (reports <= 10) begin
                    $display("result %0d mismatch, expected rd=%h pop=%b tx=%b/%h led=%b/%h err=%0d",
                             checked, e.read_data, e.rx_pop, e.tx_valid, e.tx_byte,
                             e.led_valid, e.led_value, e.error_code);
                    $display("  got rd=%h pop=%b tx=%b/%h led=%b/%h err=%0d",
                             d[31:0], d[32], d[33], d[41:34], d[42], d[50:43], d[53:51]);
                end
            end
        endfunction

        // a slot that may be read back; a fetch wants a fully written low slot
        function bit pick_slot(bit for_fetch, output int slot);
            int tries;
            slot = 0;
            if (written_slots.size() == 0)
                return 1'b0;
            for (tries = 0; tries < 8; tries++) begin
                slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
                if (!for_fetch || (slot < FETCH_LIMIT && lanes_written[slot] == 4'hF))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function int failures();
            return mismatches + strays + responses_due.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // clock, reset and the block
    // -----------------------------------------------------------------------
    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    mmio_scoreboard board = new();

    // shared between the sender and the receiver
    bit calm_phase   = 1'b0;   // no idling on either side
    bit hold_request = 1'b0;   // receiver holds off for a long stretch
    int cycle_count  = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    word_memory_with_mapped_io #(
        .MEM_WORDS         (MEM_SLOTS),
        .FETCH_LIMIT_WORDS (FETCH_LIMIT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // -----------------------------------------------------------------------
    // sender side
    // -----------------------------------------------------------------------

    // offer one access beat and note it in the scoreboard once taken;
    // called right after a rising edge, leaves tvalid high for a follow-on beat
    task automatic issue_access(input logic [1:0] mode, input logic [29:0] addr,
                                input logic [1:0] size, input logic [31:0] wdata,
                                input logic [7:0] rx);
        access_t a;
        a.mode         = mode;
        a.word_address = addr;
        a.access_size  = size;
        a.write_data   = wdata;
        a.uart_rx_byte = rx;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {rx, wdata, size, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_access(a);
    endtask

    task automatic sender_gap();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 16))
            @(posedge clk);
    endtask

    // stop offering until every result due has been taken
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.responses_due.size() != 0);
    endtask

    // one random access; ram reads and in-range fetches only go to slots already written
    task automatic random_access();
        int          pick;
        int          slot;
        logic [3:0]  lanes;
        logic [1:0]  size;
        logic [1:0]  mode;
        logic [29:0] addr;
        pick = $urandom_range(0, 99);
        size = 2'($urandom_range(0, 3));
        mode = MODE_DATA_WRITE;
        // writes cluster low so that many slots also serve as instructions
        if ($urandom_range(0, 4) < 3)
            addr = 30'($urandom_range(0, 2047));
        else
            addr = 30'($urandom_range(0, DATA_LIMIT_WORDS - 1));
        if (pick >= 32 && pick < 58 && board.pick_slot(1'b0, slot)) begin
            // read back, no wider than the lanes already written
            mode  = MODE_DATA_READ;
            addr  = 30'(slot);
            lanes = board.lanes_written[slot];
            if (lanes != 4'hF)
                size = lanes[1] ? 2'($urandom_range(0, 1)) : SIZE_BYTE;
        end else if (pick >= 58 && pick < 68) begin
            mode = MODE_FETCH;
            if (!board.pick_slot(1'b1, slot))
                slot = $urandom_range(FETCH_LIMIT, DATA_LIMIT_WORDS - 1);
            addr = 30'(slot);
        end else if (pick >= 68 && pick < 80) begin
            // either direction on any of the three ports
            mode = 2'($urandom_range(0, 1));
            case ($urandom_range(0, 2))
                0:       addr = UART_RX_WORD;
                1:       addr = UART_TX_WORD;
                default: addr = LED_WORD;
            endcase
        end else if (pick >= 80 && pick < 95) begin
            // beyond the data region, up to the top address bit
            mode = 2'($urandom_range(0, 2));
            addr = 30'($urandom_range(DATA_LIMIT_WORDS, 32'h3FFF_FFFF));
        end else if (pick >= 95) begin
            mode = MODE_NONE;
            addr = 30'($urandom);
        end
        issue_access(mode, addr, size, $urandom, 8'($urandom));
    endtask

    // -----------------------------------------------------------------------
    // receiver side: checks each result beat and idles in random bursts
    // -----------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
                board.check_result(m_axis_tdata);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                // long hold-off: the block fills and must stall its input
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // watchdog
    // -----------------------------------------------------------------------
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due",
                 cycle_count, board.responses_due.size());
        $display("tb_word_memory_with_mapped_io: done, errors");
        $finish;
    end

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    initial begin : stimulus
        int i;
        int rush_until;
        rush_until = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: widths, lane merges, region edges, ports, unused mode
        issue_access(MODE_DATA_WRITE, 30'd0, SIZE_WORD, 32'hFFFF_FFFF, 8'h00);
        issue_access(MODE_DATA_WRITE, 30'd0, SIZE_BYTE, 32'h1234_565A, 8'h00);
        issue_access(MODE_DATA_READ, 30'd0, SIZE_BYTE, 32'h0, 8'h00);
        issue_access(MODE_DATA_READ, 30'd0, SIZE_HALF, 32'h0, 8'h00);
        issue_access(MODE_DATA_WRITE, 30'd1, SIZE_HALF, 32'hCAFE_BABE, 8'h00);
        issue_access(MODE_DATA_READ, 30'd1, SIZE_HALF, 32'h0, 8'h00);
        issue_access(MODE_DATA_WRITE, 30'(FETCH_LIMIT - 1), SIZE_WIDE, 32'h1357_9BDF, 8'h00);
        // last fetchable slot, first one past it, top of the address space
        issue_access(MODE_FETCH, 30'(FETCH_LIMIT - 1), SIZE_WORD, 32'h0, 8'h00);
        issue_access(MODE_FETCH, 30'd0, SIZE_BYTE, 32'h0, 8'h00);
        issue_access(MODE_FETCH, 30'(FETCH_LIMIT), SIZE_WORD, 32'h0, 8'h00);
        issue_access(MODE_FETCH, 30'h3FFF_FFFF, SIZE_WORD, 32'h0, 8'h00);
        // last data slot, then just past the data region
        issue_access(MODE_DATA_WRITE, 30'(DATA_LIMIT_WORDS - 1), SIZE_WORD, 32'h8000_0001, 8'h00);
        issue_access(MODE_DATA_READ, 30'(DATA_LIMIT_WORDS - 1), SIZE_WIDE, 32'h0, 8'h00);
        issue_access(MODE_DATA_READ, 30'(DATA_LIMIT_WORDS), SIZE_WORD, 32'h0, 8'h00);
        issue_access(MODE_DATA_WRITE, 30'h3FFF_FFFF, SIZE_WORD, 32'hFFFF_FFFF, 8'hFF);
        // uart receive reads whatever the size, then each port in both directions
        issue_access(MODE_DATA_READ, UART_RX_WORD, SIZE_BYTE, 32'h0, 8'hFF);
        issue_access(MODE_DATA_READ, UART_RX_WORD, SIZE_WORD, 32'hFFFF_FFFF, 8'h81);
        issue_access(MODE_DATA_WRITE, UART_RX_WORD, SIZE_WORD, 32'hFFFF_FFFF, 8'h00);
        issue_access(MODE_DATA_WRITE, UART_TX_WORD, SIZE_WORD, 32'hDEAD_BEEF, 8'h00);
        issue_access(MODE_DATA_READ, UART_TX_WORD, SIZE_BYTE, 32'h0, 8'h00);
        issue_access(MODE_DATA_WRITE, LED_WORD, SIZE_BYTE, 32'hFFFF_FFC3, 8'h00);
        issue_access(MODE_DATA_READ, LED_WORD, SIZE_HALF, 32'h0, 8'h00);
        issue_access(MODE_NONE, 30'd0, SIZE_WORD, 32'hFFFF_FFFF, 8'hFF);
        issue_access(MODE_DATA_READ, 30'd0, SIZE_WORD, 32'h0, 8'h00);
        wait_drained();

        // random accesses; calm stretches and a quiet tail with no idling
        for (i = 0; i < RANDOM_ACCESSES; i++) begin
            calm_phase = (i % 300 >= 200) || (i >= RANDOM_ACCESSES - QUIET_TAIL);
            if (i == 400) begin
                // receiver stalls while the sender keeps offering back to back
                hold_request = 1'b1;
                rush_until   = i + 80;
            end
            if (i == 800)
                wait_drained();
            if (!calm_phase && i >= rush_until && $urandom_range(0, 5) == 0)
                sender_gap();
            random_access();
        end

        wait_drained();
        repeat (8)
            @(posedge clk);

        $display("covered %0d results: %0d ram reads, %0d ram writes, %0d fetches",
                 board.checked, board.mem_reads, board.mem_writes, board.fetches);
        $display("  %0d port beats, %0d error responses, %0d no-op accesses, %0d cycles",
                 board.port_hits, board.faults, board.idle_ops, cycle_count);
        if (board.failures() == 0)
            $display("tb_word_memory_with_mapped_io: done, clean");
        else
            $display("tb_word_memory_with_mapped_io: done, errors");
        $finish;
    end

endmodule
